[hdl/rcfd_pkg.sv]
`default_nettype none

package rcfd_pkg;

   // Frame geometry
   localparam int FRAME_LEN     = 25;
   localparam int CHANNEL_COUNT = 16;
   localparam int CHAN_BITS     = 11;
   localparam int POS_W         = $clog2(FRAME_LEN);
   localparam int CH_W          = $clog2(CHANNEL_COUNT);

   // Byte positions with a role of their own
   localparam logic [POS_W-1:0] POS_START = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(23);
   localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] POS_DATA  = POS_W'(1);

   // Lost-frame and failsafe bits of the flag byte
   localparam logic [7:0] FLAG_MASK = 8'h0C;

   // Scaling constants
   localparam logic signed [12:0] RAW_CENTER   = 13'sd992;
   localparam logic [15:0]        PULSE_CENTER = 16'd1500;

   // Configuration register indexes
   localparam logic [2:0] CSR_START_MARKER   = 3'd0;
   localparam logic [2:0] CSR_END_MARKER     = 3'd1;
   localparam logic [2:0] CSR_ACQUIRE_FRAMES = 3'd2;
   localparam logic [2:0] CSR_PULSE_FLOOR    = 3'd3;
   localparam logic [2:0] CSR_PULSE_CEILING  = 3'd4;
   localparam logic [2:0] CSR_SKIP_FRAMES    = 3'd5;

   typedef enum logic [1:0] {
      LINK_NOSYNC   = 2'd0,
      LINK_ACQUIRE  = 2'd1,
      LINK_READY    = 2'd2,
      LINK_FAILSAFE = 2'd3
   } link_type;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [7:0]  end_marker;
      logic [7:0]  acquire_frames;
      logic [11:0] pulse_floor;
      logic [11:0] pulse_ceiling;
      logic [7:0]  skip_frames;
   } cfg_type;

   // Command from front to back, one per accepted request
   typedef struct packed {
      link_type link_state;
      logic     publish;
   } cmd_type;

   // Frame store write from the front
   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

   typedef struct packed {
      link_type        link_state;
      logic            new_frame;
      logic [CH_W-1:0] channel_index;
      logic [11:0]     pulse_width;
      logic            last;
   } rsp_type;

   // Scale an 11-bit channel value to a pulse width, truncating toward zero
   function automatic logic [11:0] scale_pulse(input logic [CHAN_BITS-1:0] v);
      logic signed [12:0] diff;
      logic signed [15:0] prod;
      logic [15:0]        mag;
      logic [15:0]        sum;
      diff = $signed({2'b00, v}) - RAW_CENTER;
      prod = ({{3{diff[12]}}, diff} <<< 2) + {{3{diff[12]}}, diff};
      mag  = prod[15] ? 16'(-prod) : 16'(prod);
      sum  = prod[15] ? (PULSE_CENTER - {3'b000, mag[15:3]})
                      : (PULSE_CENTER + {3'b000, mag[15:3]});
      return sum[11:0];
   endfunction

endpackage

`default_nettype wire

[hdl/rcfd_front.sv]
`default_nettype none

module rcfd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rcfd_pkg::cfg_type     cfg,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  rx_error,
   input  wire logic                  gap_flag,
   input  wire logic                  unpack_done,
   output rcfd_pkg::store_wr_type     store_wr,
   output logic                       cmd_push,
   output rcfd_pkg::cmd_type          cmd,
   output logic                       busy
);

   logic [rcfd_pkg::POS_W-1:0] pos_ff, pos_in;
   rcfd_pkg::link_type         sync_ff, sync_in;
   logic [7:0]                 run_ff, run_in;
   logic [7:0]                 skip_ff, skip_in;
   logic [7:0]                 flags_ff, flags_in;
   logic                       busy_ff, busy_in;
   logic                       publish;
   logic [7:0]                 run_inc;
   logic [7:0]                 skip_inc;

   assign run_inc  = run_ff + 8'd1;
   assign skip_inc = skip_ff + 8'd1;

   // Classify the request and advance the framing state
   always_comb begin
      pos_in   = pos_ff;
      sync_in  = sync_ff;
      run_in   = run_ff;
      skip_in  = skip_ff;
      flags_in = flags_ff;
      publish  = 1'b0;
      store_wr = '{en: 1'b0, addr: pos_ff, data: data_byte};
      if (accept) begin
         priority if (rx_error) begin
            pos_in  = rcfd_pkg::POS_START;
            sync_in = rcfd_pkg::LINK_FAILSAFE;
         end else if (pos_ff == rcfd_pkg::POS_START) begin
            if (gap_flag && data_byte == cfg.start_marker) begin
               store_wr.en = 1'b1;
               pos_in      = rcfd_pkg::POS_DATA;
               if (sync_ff == rcfd_pkg::LINK_NOSYNC) begin
                  sync_in = rcfd_pkg::LINK_ACQUIRE;
                  run_in  = 8'd0;
               end
            end
         end else if (gap_flag) begin
            pos_in = rcfd_pkg::POS_START;
            run_in = 8'd0;
            if (sync_ff == rcfd_pkg::LINK_READY) begin
               sync_in = rcfd_pkg::LINK_FAILSAFE;
            end
         end else begin
            store_wr.en = 1'b1;
            if (pos_ff == rcfd_pkg::POS_FLAGS) begin
               flags_in = data_byte;
            end
            if (pos_ff == rcfd_pkg::POS_END) begin
               pos_in = rcfd_pkg::POS_START;
               if (data_byte == cfg.end_marker) begin
                  if ((flags_ff & rcfd_pkg::FLAG_MASK) != 8'd0) begin
                     sync_in = rcfd_pkg::LINK_FAILSAFE;
                  end else begin
                     if (sync_ff == rcfd_pkg::LINK_ACQUIRE) begin
                        run_in = run_inc;
                        if (run_inc >= cfg.acquire_frames) begin
                           sync_in = rcfd_pkg::LINK_READY;
                        end
                     end else begin
                        sync_in = rcfd_pkg::LINK_READY;
                        run_in  = 8'd0;
                     end
                     skip_in = skip_inc;
                     if (skip_inc > cfg.skip_frames) begin
                        skip_in = 8'd0;
                        publish = 1'b1;
                     end
                  end
               end
            end else begin
               pos_in = pos_ff + rcfd_pkg::POS_W'(1);
            end
         end
      end
   end

   // Hold off new requests while the back end reads the frame store
   always_comb begin
      busy_in = busy_ff;
      if (unpack_done) begin
         busy_in = 1'b0;
      end
      if (publish) begin
         busy_in = 1'b1;
      end
   end

   assign cmd_push = accept;
   assign cmd      = '{link_state: sync_in, publish: publish};
   assign busy     = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= rcfd_pkg::POS_START;
         sync_ff <= rcfd_pkg::LINK_NOSYNC;
         run_ff  <= 8'd0;
         skip_ff <= 8'd0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         sync_ff <= sync_in;
         run_ff  <= run_in;
         skip_ff <= skip_in;
         busy_ff <= busy_in;
      end
      flags_ff <= flags_in;
   end

endmodule

`default_nettype wire

[hdl/rcfd_cmd_fifo.sv]
`default_nettype none

module rcfd_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rcfd_pkg::cmd_type push_data,
   input  wire logic              pop,
   output rcfd_pkg::cmd_type      head,
   output logic                   empty,
   output logic                   full
);

   rcfd_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/rcfd_rsp_fifo.sv]
`default_nettype none

module rcfd_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rcfd_pkg::rsp_type push_data,
   input  wire logic              pop,
   output rcfd_pkg::rsp_type      head,
   output logic                   empty,
   output logic                   full
);

   rcfd_pkg::rsp_type entry_ff [4];
   logic [1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [2:0]        count_ff;
   logic              do_push, do_pop;

   assign empty   = (count_ff == 3'd0);
   assign full    = (count_ff == 3'd4);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {2'b00, do_push} - {2'b00, do_pop};
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/rcfd_back.sv]
`default_nettype none

module rcfd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rcfd_pkg::cfg_type      cfg,
   input  wire rcfd_pkg::store_wr_type store_wr,
   input  wire rcfd_pkg::cmd_type      cmd,
   input  wire logic                   cmd_empty,
   output logic                        cmd_pop,
   input  wire logic                   rsp_full,
   output logic                        rsp_push,
   output rcfd_pkg::rsp_type           rsp,
   output logic                        unpack_done
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MERGE,
      ST_CALC
   } state_type;

   localparam int ACC_W = rcfd_pkg::CHAN_BITS + 7;

   logic [7:0] frame_store [rcfd_pkg::FRAME_LEN];

   state_type                    state_ff, state_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [4:0]                   have_ff, have_in;
   logic [rcfd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [rcfd_pkg::CH_W-1:0]    ch_ff, ch_in;
   rcfd_pkg::link_type           link_ff, link_in;
   logic                         done_ff, done_in;
   logic [7:0]                   rd_data_ff;
   logic [11:0]                  pulse_ff [rcfd_pkg::CHANNEL_COUNT];
   logic                         pulse_we;
   logic [11:0]                  pulse;
   logic                         in_range;
   logic [11:0]                  width;
   logic [4:0]                   have_add;
   logic [4:0]                   have_sub;

   // Frame store: written by the front, read one byte a cycle here
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         frame_store[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= frame_store[pos_ff];
   end

   assign pulse    = rcfd_pkg::scale_pulse(acc_ff[rcfd_pkg::CHAN_BITS-1:0]);
   assign in_range = (pulse > cfg.pulse_floor) && (pulse < cfg.pulse_ceiling);
   assign width    = in_range ? pulse : pulse_ff[ch_ff];
   assign have_add = have_ff + 5'd8;
   assign have_sub = have_ff - 5'(rcfd_pkg::CHAN_BITS);

   // Unpack a frame one channel per calc step, or forward a command
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      have_in  = have_ff;
      pos_in   = pos_ff;
      ch_in    = ch_ff;
      link_in  = link_ff;
      done_in  = 1'b0;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      pulse_we = 1'b0;
      rsp      = '{link_state: link_ff, new_frame: 1'b0, channel_index: '0,
                   pulse_width: 12'd0, last: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            rsp.link_state = cmd.link_state;
            if (!cmd_empty) begin
               if (cmd.publish) begin
                  cmd_pop  = 1'b1;
                  link_in  = cmd.link_state;
                  acc_in   = '0;
                  have_in  = 5'd0;
                  pos_in   = rcfd_pkg::POS_DATA;
                  ch_in    = '0;
                  state_in = ST_FETCH;
               end else if (!rsp_full) begin
                  cmd_pop  = 1'b1;
                  rsp_push = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            acc_in   = acc_ff | (ACC_W'(rd_data_ff) << have_ff);
            have_in  = have_add;
            pos_in   = pos_ff + rcfd_pkg::POS_W'(1);
            state_in = (have_add >= 5'(rcfd_pkg::CHAN_BITS)) ? ST_CALC : ST_FETCH;
         end
         ST_CALC: begin
            rsp.new_frame     = 1'b1;
            rsp.channel_index = ch_ff;
            rsp.pulse_width   = width;
            rsp.last          = (ch_ff == rcfd_pkg::CH_W'(rcfd_pkg::CHANNEL_COUNT - 1));
            if (!rsp_full) begin
               rsp_push = 1'b1;
               pulse_we = in_range;
               acc_in   = acc_ff >> rcfd_pkg::CHAN_BITS;
               have_in  = have_sub;
               ch_in    = ch_ff + rcfd_pkg::CH_W'(1);
               if (rsp.last) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else if (have_sub < 5'(rcfd_pkg::CHAN_BITS)) begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign unpack_done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         for (int i = 0; i < rcfd_pkg::CHANNEL_COUNT; i++) begin
            pulse_ff[i] <= rcfd_pkg::PULSE_CENTER[11:0];
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         if (pulse_we) begin
            pulse_ff[ch_ff] <= pulse;
         end
      end
      acc_ff  <= acc_in;
      have_ff <= have_in;
      pos_ff  <= pos_in;
      ch_ff   <= ch_in;
      link_ff <= link_in;
   end

endmodule

`default_nettype wire

[hdl/rc_serial_frame_decoder_unit.sv]
`default_nettype none

// Channel   Handshake           Payload
// req       req_push/req_full   data_byte, rx_error, gap_flag
// rsp       rsp_pop/rsp_empty   link_state, new_frame, channel_index, pulse_width, last
// csr       csr_valid/csr_ready csr_index, csr_data (always ready)
//
// A byte that publishes no frame goes from the front into the command queue; the back end
// moves its result into the result queue, whose head drives the rsp ports. A publishing
// byte makes the back end unpack the frame store, fetching and merging each byte and
// scaling each channel; req_full stays high until it is done, and longer on rsp stalls.
// Synchronous reset clears the framing state, sets all pulse widths to 1500 and the
// registers to their defaults; the frame store needs no clearing pass.
// A stalled rsp side fills a four-deep result queue, then backs up into the request side.

module rc_serial_frame_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_rx_error,
   input  wire logic        req_gap_flag,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_link_state,
   output logic             rsp_new_frame,
   output logic [3:0]       rsp_channel_index,
   output logic [11:0]      rsp_pulse_width,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   rcfd_pkg::cfg_type      cfg_ff;
   rcfd_pkg::store_wr_type store_wr;
   rcfd_pkg::cmd_type      cmd_in, cmd_head;
   rcfd_pkg::rsp_type      rsp_in, rsp_head;
   logic                   cmd_push, cmd_pop, cmd_empty, cmd_full;
   logic                   rsp_push, rsp_full;
   logic                   unpack_done;
   logic                   busy;
   logic                   accept;

   // Register file writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_marker: 8'd15, end_marker: 8'd0, acquire_frames: 8'd10,
                     pulse_floor: 12'd750, pulse_ceiling: 12'd2250, skip_frames: 8'd0};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rcfd_pkg::CSR_START_MARKER:   cfg_ff.start_marker   <= csr_data[7:0];
            rcfd_pkg::CSR_END_MARKER:     cfg_ff.end_marker     <= csr_data[7:0];
            rcfd_pkg::CSR_ACQUIRE_FRAMES: cfg_ff.acquire_frames <= csr_data[7:0];
            rcfd_pkg::CSR_PULSE_FLOOR:    cfg_ff.pulse_floor    <= csr_data;
            rcfd_pkg::CSR_PULSE_CEILING:  cfg_ff.pulse_ceiling  <= csr_data;
            rcfd_pkg::CSR_SKIP_FRAMES:    cfg_ff.skip_frames    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   assign req_full = cmd_full || busy;
   assign accept   = req_push && !req_full;

   rcfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .rx_error    (req_rx_error),
      .gap_flag    (req_gap_flag),
      .unpack_done (unpack_done),
      .store_wr    (store_wr),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in),
      .busy        (busy)
   );

   rcfd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   rcfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .store_wr    (store_wr),
      .cmd         (cmd_head),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (rsp_in),
      .unpack_done (unpack_done)
   );

   rcfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty),
      .full      (rsp_full)
   );

   // Drive result ports from the queue head
   assign rsp_link_state    = rsp_head.link_state;
   assign rsp_new_frame     = rsp_head.new_frame;
   assign rsp_channel_index = rsp_head.channel_index;
   assign rsp_pulse_width   = rsp_head.pulse_width;
   assign rsp_last          = rsp_head.last;

endmodule

`default_nettype wire
